[rtl/core/activity_aging_table_macros.svh]
// Assertion macros shared by the RTL of the activity aging table.
`ifndef ACTIVITY_AGING_TABLE_MACROS_SVH
`define ACTIVITY_AGING_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define AAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("activity_aging_table: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define AAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("activity_aging_table: next-cycle check failed");
`else
`define AAT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AAT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/aat_pkg.sv]
package aat_pkg;

  localparam int IDX_W   = 12;
  localparam int AGE_W   = 16;
  localparam int CNT_W   = 13;
  localparam int ACT_W   = 3;

  typedef logic [IDX_W-1:0] index_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_IDLE     = 3'd0;
  localparam action_t ACT_ACTIVATE = 3'd1;
  localparam action_t ACT_REFRESH  = 3'd2;
  localparam action_t ACT_AGE_DOWN = 3'd3;
  localparam action_t ACT_EXPIRE   = 3'd4;

  localparam age_t   LIMIT_RESET = 16'd4;
  localparam age_t   AGE_MAX     = 16'hFFFF;
  localparam age_t   AGE_ONE     = 16'd1;
  localparam count_t COUNT_MAX   = 13'h1FFF;

endpackage

[rtl/core/aat_in_if.sv]
interface aat_in_if;
  import aat_pkg::*;

  logic   valid;
  logic   ready;
  index_t entry_index;
  logic   seen;
  logic   last_of_sweep;

  modport source (output valid, output entry_index, output seen, output last_of_sweep,
                  input ready);
  modport sink (input valid, input entry_index, input seen, input last_of_sweep,
                output ready);
endinterface

[rtl/core/aat_out_if.sv]
interface aat_out_if;
  import aat_pkg::*;

  logic    valid;
  logic    ready;
  index_t  result_index;
  action_t action;
  logic    clear_flag;
  logic    still_active;
  logic    sweep_done;
  count_t  seen_total;
  count_t  active_total;

  modport source (output valid, output result_index, output action, output clear_flag,
                  output still_active, output sweep_done, output seen_total,
                  output active_total, input ready);
  modport sink (input valid, input result_index, input action, input clear_flag,
                input still_active, input sweep_done, input seen_total,
                input active_total, output ready);
endinterface

[rtl/core/activity_aging_table.sv]
// Activity aging table. Each input transaction names one table entry and
// whether it was seen; the block reads that entry's age from a single
// synchronous memory, updates it and writes it back, and returns exactly one
// result transaction per input, through the stage 1 and output registers.
// A new transaction can be accepted every cycle while the output is not
// stalled: the rate is set by the memory's one read and one write per cycle,
// with the write of the previous transaction forwarded when the next one
// addresses the same entry. After reset the block loads all min(ENTRIES,
// 4096) ages with the reset limit of 4, one entry per cycle, and accepts no
// input until that pass ends; aging_limit writes are taken throughout.
// Indexes at or beyond ENTRIES leave the table alone and report idle.
`include "activity_aging_table_macros.svh"

module activity_aging_table #(
  parameter int ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  aat_in_if.sink            in_chan,
  aat_out_if.source         out_chan,
  input  logic              cfg_wr_en,
  input  aat_pkg::age_t     cfg_wr_data
);
  import aat_pkg::*;

  localparam int DEPTH = (ENTRIES < (1 << IDX_W)) ? ENTRIES : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // Configuration.
  age_t aging_limit_r;
  age_t new_age;

  // Clearing pass after reset.
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // Stage 1: the item whose memory read is in flight.
  logic          s1_valid_r;
  index_t        s1_idx_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_seen_r;
  logic          s1_last_r;
  logic          s1_in_range_r;
  age_t          rdata_r;

  // Last write made by an item, forwarded to the next read of the same entry.
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  age_t          fwd_data_r;

  count_t seen_count_r;
  count_t active_count_r;

  // Output register.
  logic    out_valid_r;
  index_t  out_idx_r;
  action_t out_action_r;
  logic    out_clear_r;
  logic    out_active_r;
  logic    out_done_r;
  count_t  out_seen_total_r;
  count_t  out_active_total_r;

  age_t    age_mem [DEPTH];

  logic          in_fire;
  logic          s1_advance;
  logic          s1_fire;
  logic          in_range;
  logic [AW-1:0] rd_addr;
  age_t          cur_age;
  logic          item_we;
  age_t          item_wdata;
  action_t       item_action;
  logic          item_clear;
  logic          item_active;
  logic          inc_seen;
  logic          inc_active;
  count_t        seen_count_nxt;
  count_t        active_count_nxt;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  age_t          mem_wdata;

  assign new_age    = (aging_limit_r == AGE_MAX) ? AGE_MAX : aging_limit_r + AGE_ONE;
  assign s1_advance = !out_valid_r || out_chan.ready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign in_chan.ready = !clearing_r && (!s1_valid_r || s1_advance);
  assign in_fire    = in_chan.valid && in_chan.ready;
  assign in_range   = (32'(in_chan.entry_index) < 32'(ENTRIES));
  assign rd_addr    = in_chan.entry_index[AW-1:0];

  assign cur_age = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : rdata_r;

  always_comb begin
    item_we     = 1'b0;
    item_wdata  = cur_age;
    item_action = ACT_IDLE;
    item_clear  = 1'b0;
    item_active = 1'b0;
    inc_seen    = 1'b0;
    inc_active  = 1'b0;
    if (s1_in_range_r) begin
      if (s1_seen_r) begin
        item_we     = 1'b1;
        item_wdata  = new_age;
        item_action = (cur_age == '0) ? ACT_ACTIVATE : ACT_REFRESH;
        item_clear  = 1'b1;
        item_active = 1'b1;
        inc_seen    = 1'b1;
        inc_active  = 1'b1;
      end else if (cur_age > AGE_ONE) begin
        item_we     = 1'b1;
        item_wdata  = cur_age - AGE_ONE;
        item_action = ACT_AGE_DOWN;
        item_active = 1'b1;
        inc_active  = 1'b1;
      end else if (cur_age == AGE_ONE) begin
        item_we     = 1'b1;
        item_wdata  = '0;
        item_action = ACT_EXPIRE;
      end
    end
  end

  // Both totals saturate at the top of their range.
  assign seen_count_nxt = (inc_seen && (seen_count_r != COUNT_MAX)) ?
                          seen_count_r + 13'd1 : seen_count_r;
  assign active_count_nxt = (inc_active && (active_count_r != COUNT_MAX)) ?
                            active_count_r + 13'd1 : active_count_r;

  assign mem_we    = clearing_r || (s1_fire && item_we);
  assign mem_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clearing_r ? LIMIT_RESET : item_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      age_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rdata_r <= age_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      aging_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r      <= in_chan.entry_index;
      s1_addr_r     <= rd_addr;
      s1_seen_r     <= in_chan.seen;
      s1_last_r     <= in_chan.last_of_sweep;
      s1_in_range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (s1_fire && item_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && item_we) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= item_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_count_r   <= '0;
      active_count_r <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        seen_count_r   <= '0;
        active_count_r <= '0;
      end else begin
        seen_count_r   <= seen_count_nxt;
        active_count_r <= active_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_idx_r          <= s1_idx_r;
      out_action_r       <= item_action;
      out_clear_r        <= item_clear;
      out_active_r       <= item_active;
      out_done_r         <= s1_last_r;
      out_seen_total_r   <= s1_last_r ? seen_count_nxt : '0;
      out_active_total_r <= s1_last_r ? active_count_nxt : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_index = out_idx_r;
  assign out_chan.action       = out_action_r;
  assign out_chan.clear_flag   = out_clear_r;
  assign out_chan.still_active = out_active_r;
  assign out_chan.sweep_done   = out_done_r;
  assign out_chan.seen_total   = out_seen_total_r;
  assign out_chan.active_total = out_active_total_r;

  // No item may be in flight while the clearing pass owns the write port.
  `AAT_ASSERT_IMP(a_no_item_while_clearing, clk, rst_n, clearing_r, !s1_valid_r)
  // Every seen entry counts towards both totals, so seen never runs ahead.
  `AAT_ASSERT_IMP(a_seen_within_active, clk, rst_n, 1'b1, seen_count_r <= active_count_r)
  // A seen, in-range item leaves a result that clears the flag and stays active.
  `AAT_ASSERT_NXT(a_seen_result, clk, rst_n, s1_fire && s1_in_range_r && s1_seen_r,
                  out_valid_r && out_clear_r && out_active_r)
  // Totals are only shown on the transaction that ends a sweep.
  `AAT_ASSERT_IMP(a_totals_only_at_end, clk, rst_n, out_valid_r && !out_done_r,
                  (out_seen_total_r == '0) && (out_active_total_r == '0))

endmodule

[sim/aging_result_checker.sv]
module aging_result_checker #(
  parameter int ENTRIES = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  aat_in_if             in_mon,
  aat_out_if            out_mon,
  input  logic          cfg_wr_en,
  input  aat_pkg::age_t cfg_wr_data,
  output int            mismatches,
  output int            pending
);
  import aat_pkg::*;

  typedef struct {
    index_t  idx;
    action_t action;
    logic    clear_flag;
    logic    still_active;
    logic    sweep_done;
    count_t  seen_total;
    count_t  active_total;
  } aging_result_t;

  age_t          age_mem [ENTRIES];
  age_t          limit;
  count_t        seen_cnt;
  count_t        active_cnt;
  aging_result_t expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input index_t idx);
    if (got !== want) begin
      report_mismatch($sformatf("entry %0h field %s got %0h expected %0h",
                                idx, name, got, want));
    end
  endtask

  function automatic count_t bump(input count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Ages one entry and returns the result the block must produce for it.
  function automatic aging_result_t age_entry(input index_t idx, input logic seen,
                                              input logic last);
    aging_result_t r;
    age_t          age;
    r.idx          = idx;
    r.action       = ACT_IDLE;
    r.clear_flag   = 1'b0;
    r.still_active = 1'b0;
    if (int'(idx) < ENTRIES) begin
      age = age_mem[idx];
      if (seen) begin
        r.action       = (age == '0) ? ACT_ACTIVATE : ACT_REFRESH;
        age_mem[idx]   = (limit == AGE_MAX) ? AGE_MAX : limit + AGE_ONE;
        r.clear_flag   = 1'b1;
        r.still_active = 1'b1;
        seen_cnt       = bump(seen_cnt);
        active_cnt     = bump(active_cnt);
      end else if (age > AGE_ONE) begin
        age_mem[idx]   = age - AGE_ONE;
        r.action       = ACT_AGE_DOWN;
        r.still_active = 1'b1;
        active_cnt     = bump(active_cnt);
      end else if (age == AGE_ONE) begin
        age_mem[idx] = '0;
        r.action     = ACT_EXPIRE;
      end
    end
    r.sweep_done   = last;
    r.seen_total   = last ? seen_cnt : '0;
    r.active_total = last ? active_cnt : '0;
    if (last) begin
      seen_cnt   = '0;
      active_cnt = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    aging_result_t want;
    if (!rst_n) begin
      foreach (age_mem[i]) age_mem[i] = LIMIT_RESET;
      limit      = LIMIT_RESET;
      seen_cnt   = '0;
      active_cnt = '0;
      mismatches = 0;
      expected_q.delete();
    end else begin
      // Results are retired before new transactions are queued, so a result
      // can never be matched against its own input.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result for entry %0h with nothing outstanding",
                                    out_mon.result_index));
        end else begin
          want = expected_q.pop_front();
          compare_field("result_index", 16'(out_mon.result_index), 16'(want.idx),
                        want.idx);
          compare_field("action", 16'(out_mon.action), 16'(want.action), want.idx);
          compare_field("clear_flag", 16'(out_mon.clear_flag), 16'(want.clear_flag),
                        want.idx);
          compare_field("still_active", 16'(out_mon.still_active),
                        16'(want.still_active), want.idx);
          compare_field("sweep_done", 16'(out_mon.sweep_done), 16'(want.sweep_done),
                        want.idx);
          compare_field("seen_total", 16'(out_mon.seen_total), 16'(want.seen_total),
                        want.idx);
          compare_field("active_total", 16'(out_mon.active_total),
                        16'(want.active_total), want.idx);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.insert(expected_q.size(),
                          age_entry(in_mon.entry_index, in_mon.seen,
                                    in_mon.last_of_sweep));
      end
      if (cfg_wr_en) begin
        limit = cfg_wr_data;
      end
    end
    pending <= expected_q.size();
  end

endmodule

[sim/activity_aging_table_test.sv]
module activity_aging_table_test;
  import aat_pkg::*;

  localparam int ENTRIES        = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLDOFF_CYCLES = 80;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_wr_en;
  age_t     cfg_wr_data;
  int       mismatches;
  int       pending;

  rx_mode_t rx_mode = RX_OPEN;
  int       holdoff_req = 0;
  int       holdoff_seen = 0;
  int       hold_left = 0;
  int       rx_tick = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  int       items_sent = 0;
  int       sweeps_sent = 0;
  int       limits_used = 0;

  aat_in_if  in_chan ();
  aat_out_if out_chan ();

  always #5 clk = ~clk;

  activity_aging_table #(.ENTRIES(ENTRIES)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  aging_result_checker #(.ENTRIES(ENTRIES)) u_results (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // Receiver: a long hold-off on request, otherwise the stall pattern of the
  // current mode.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen   <= holdoff_req;
      hold_left      <= HOLDOFF_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_chan.ready <= 1'b1;
        RX_RANDOM:  out_chan.ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_chan.ready <= ((rx_tick % 5) != 0) && ((rx_tick % 7) != 3);
        default:    out_chan.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_entry(input index_t idx, input logic seen, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_chan.valid         <= 1'b1;
    in_chan.entry_index   <= idx;
    in_chan.seen          <= seen;
    in_chan.last_of_sweep <= last;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (last) sweeps_sent++;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    burst_left = 0;
  endtask

  task automatic set_limit(input age_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limits_used++;
  endtask

  initial begin
    int      pool_base;
    int      pool_size;
    int      seen_pct;
    int      phase_start;
    bit      paused;
    age_t    phase_limit;

    in_chan.valid         <= 1'b0;
    in_chan.entry_index   <= '0;
    in_chan.seen          <= 1'b0;
    in_chan.last_of_sweep <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limit: an entry ages from 4 down to expiry, then sits idle
    // until it is seen again.
    repeat (3) send_entry(12'h000, 1'b0, 1'b0);
    send_entry(12'h000, 1'b0, 1'b0);
    send_entry(12'h000, 1'b0, 1'b0);
    send_entry(12'h000, 1'b1, 1'b0);
    send_entry(12'h000, 1'b1, 1'b0);
    send_entry(12'hFFF, 1'b1, 1'b0);
    send_entry(12'hAAA, 1'b0, 1'b0);
    send_entry(12'h555, 1'b1, 1'b0);
    send_entry(12'hFFF, 1'b0, 1'b1);

    // Largest limit: the new age saturates rather than wrapping to zero.
    drain();
    set_limit(AGE_MAX);
    send_entry(12'h001, 1'b1, 1'b0);
    send_entry(12'h001, 1'b0, 1'b1);

    // Zero limit: a sighting lasts one interval.
    drain();
    set_limit('0);
    send_entry(12'h002, 1'b1, 1'b0);
    send_entry(12'h002, 1'b0, 1'b0);
    send_entry(12'h002, 1'b0, 1'b0);
    send_entry(12'h002, 1'b1, 1'b1);

    drain();
    set_limit(16'd1);
    send_entry(12'h003, 1'b1, 1'b0);
    send_entry(12'h003, 1'b0, 1'b0);
    send_entry(12'h003, 1'b0, 1'b0);
    send_entry(12'h003, 1'b0, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase % 4)
        0:       phase_limit = age_t'($urandom_range(0, 3));
        1:       phase_limit = age_t'($urandom_range(2, 12));
        2:       phase_limit = (phase == 6) ? 16'd65534 : age_t'($urandom_range(0, 65535));
        default: phase_limit = '0;
      endcase
      set_limit(phase_limit);
      rx_mode <= rx_mode_t'(phase % 4);
      gaps_on = (phase % 3) != 1;
      if (phase == 2) begin
        holdoff_req <= holdoff_req + 1;
      end
      pool_base   = $urandom_range(0, 4095);
      pool_size   = $urandom_range(3, 24);
      seen_pct    = $urandom_range(10, 60);
      phase_start = items_sent;
      paused      = 1'b0;
      while (items_sent - phase_start < 95) begin
        if ($urandom_range(0, 4) != 0) begin
          // A well-formed sweep over the phase's pool of entries.
          for (int k = 0; k < pool_size; k++) begin
            send_entry(index_t'(pool_base + k), $urandom_range(0, 99) < seen_pct,
                       k == pool_size - 1);
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_entry(index_t'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 9) == 0);
          end
        end
        if (phase == 5 && !paused && items_sent - phase_start > 50) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d transactions in %0d sweeps under %0d aging_limit settings,",
             items_sent, sweeps_sent, limits_used);
    $display("with limit extremes, random entries, a receiver hold-off and full drains.");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
